// ===== design/adtr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the axis deadzone / trigger remap unit.
// No dependencies; used by adtr_div and the top level.

package adtr_pkg;

  // Fixed-point scale: one unit is 2^FRAC_BITS.
  localparam int FRAC_BITS    = 15;
  localparam int VAL_W        = 18;
  localparam int SPAN_W       = 16;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int ONE_INT      = 1 << FRAC_BITS;
  localparam int MIN_SPAN_INT = (ONE_INT + 999) / 1000;

  localparam logic signed [VAL_W-1:0] ONE_Q    = VAL_W'(ONE_INT);
  localparam logic [SPAN_W-1:0]       MIN_SPAN = SPAN_W'(MIN_SPAN_INT);

  // Register word indexes on the APB port.
  typedef enum logic [2:0] {
    REG_IS_STICK   = 3'd0,
    REG_TRIG_MIN   = 3'd1,
    REG_TRIG_MAX   = 3'd2,
    REG_REST_OFS   = 3'd3,
    REG_DZ_RADIUS  = 3'd4
  } reg_idx_e;

  // How the result of a request is formed.
  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_DIV,
    KIND_STICK
  } kind_e;

  // One request travelling through the divider stages.
  typedef struct packed {
    logic                    is_div;
    logic signed [VAL_W-1:0] value;
    logic [SPAN_W-1:0]       rem;
    logic [SPAN_W-1:0]       span;
    logic [FRAC_BITS-1:0]    quo;
  } div_item_t;

endpackage

// ===== design/adtr_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, plus an output stage.
// Depends on adtr_pkg for the request struct and widths.

module adtr_div (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  adtr_pkg::div_item_t                     in_item_i,
  output logic                                    out_valid_o,
  output logic signed [adtr_pkg::VAL_W-1:0]       out_value_o
);

  localparam int NSTAGE = adtr_pkg::FRAC_BITS;

  adtr_pkg::div_item_t             stage_d [NSTAGE];
  adtr_pkg::div_item_t             stage_q [NSTAGE];
  logic [NSTAGE-1:0]               valid_d;
  logic [NSTAGE-1:0]               valid_q;
  logic                            out_valid_q;
  logic signed [adtr_pkg::VAL_W-1:0] out_value_d;
  logic signed [adtr_pkg::VAL_W-1:0] out_value_q;

  // Each stage: double the remainder, subtract the span when it fits.
  always_comb begin
    adtr_pkg::div_item_t      src;
    logic [adtr_pkg::SPAN_W:0] two_rem;
    logic [adtr_pkg::SPAN_W:0] diff;
    logic                      ge;
    for (int i = 0; i < NSTAGE; i++) begin
      src        = (i == 0) ? in_item_i : stage_q[(i == 0) ? 0 : i - 1];
      valid_d[i] = (i == 0) ? in_valid_i : valid_q[(i == 0) ? 0 : i - 1];
      two_rem    = {src.rem, 1'b0};
      diff       = two_rem - {1'b0, src.span};
      ge         = (two_rem >= {1'b0, src.span});
      stage_d[i]      = src;
      stage_d[i].rem  = ge ? diff[adtr_pkg::SPAN_W-1:0] : two_rem[adtr_pkg::SPAN_W-1:0];
      stage_d[i].quo  = {src.quo[adtr_pkg::FRAC_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NSTAGE; i++) begin
      stage_q[i] <= stage_d[i];
    end
  end

  // Pick the quotient or the value fixed upstream.
  always_comb begin
    if (stage_q[NSTAGE-1].is_div) begin
      out_value_d = $signed({{(adtr_pkg::VAL_W - adtr_pkg::FRAC_BITS){1'b0}},
                             stage_q[NSTAGE-1].quo});
    end else begin
      out_value_d = stage_q[NSTAGE-1].value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= valid_q[NSTAGE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;

endmodule

// ===== design/axis_deadzone_trigger_remap_unit.sv =====
`timescale 1ns / 1ps
// Axis deadzone and trigger range remap unit, top level.
// Throughput: one request per cycle.
// The depth is set by the divider, one quotient bit per stage (15 stages).
// busy is always low and the receiver cannot stall; done_o pulses for one cycle.
// Reset clears all valid bits and the configuration registers to zero.
// Depends on adtr_pkg and adtr_div.

module axis_deadzone_trigger_remap_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // APB configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [adtr_pkg::ADDR_W-1:0]           paddr,
  input  logic [adtr_pkg::DATA_W-1:0]           pwdata,
  output logic [adtr_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  // Request side
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [16:0]                    raw_value_i,
  input  logic signed [16:0]                    partner_value_i,
  input  logic                                  has_partner_i,
  input  logic                                  partner_offset_valid_i,
  input  logic signed [16:0]                    partner_rest_offset_i,
  input  logic                                  is_trigger_i,
  input  logic                                  comp_allowed_i,
  // Result side
  output logic                                  done_o,
  output logic signed [17:0]                    corrected_value_o
);

  localparam int VW = adtr_pkg::VAL_W;
  localparam int SW = adtr_pkg::SPAN_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic              is_stick_q;
  logic [15:0]       trigger_min_q;
  logic [15:0]       trigger_max_q;
  logic signed [16:0] rest_offset_q;
  logic [15:0]       deadzone_radius_q;

  logic              cfg_wr;
  adtr_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = adtr_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_stick_q        <= 1'b0;
      trigger_min_q     <= '0;
      trigger_max_q     <= '0;
      rest_offset_q     <= '0;
      deadzone_radius_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        adtr_pkg::REG_IS_STICK:  is_stick_q        <= pwdata[0];
        adtr_pkg::REG_TRIG_MIN:  trigger_min_q     <= pwdata[15:0];
        adtr_pkg::REG_TRIG_MAX:  trigger_max_q     <= pwdata[15:0];
        adtr_pkg::REG_REST_OFS:  rest_offset_q     <= $signed(pwdata[16:0]);
        adtr_pkg::REG_DZ_RADIUS: deadzone_radius_q <= pwdata[15:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      adtr_pkg::REG_IS_STICK:  prdata = {31'b0, is_stick_q};
      adtr_pkg::REG_TRIG_MIN:  prdata = {16'b0, trigger_min_q};
      adtr_pkg::REG_TRIG_MAX:  prdata = {16'b0, trigger_max_q};
      adtr_pkg::REG_REST_OFS:  prdata = {{15{rest_offset_q[16]}}, rest_offset_q};
      adtr_pkg::REG_DZ_RADIUS: prdata = {16'b0, deadzone_radius_q};
      default:                 prdata = '0;
    endcase
  end

  // Every cycle may take a request; the pipeline never stalls.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage A: offsets, trigger numerator and span, classify the request
  // ---------------------------------------------------------------------
  logic signed [VW-1:0] raw_x;
  logic signed [VW-1:0] v_d;
  logic signed [VW-1:0] pv_x;
  logic signed [VW-1:0] p_d;
  logic signed [VW-1:0] num_d;
  logic [16:0]          top;
  logic signed [VW-1:0] span_raw;
  logic [SW-1:0]        span_d;
  logic                 range_on;
  logic signed [VW-1:0] trig_clamp;
  adtr_pkg::kind_e      kind_a_d;
  logic signed [VW-1:0] fixed_a_d;

  assign raw_x    = {raw_value_i[16], raw_value_i};
  assign v_d      = raw_x - {rest_offset_q[16], rest_offset_q};
  assign pv_x     = {partner_value_i[16], partner_value_i};
  assign p_d      = partner_offset_valid_i
                  ? pv_x - {partner_rest_offset_i[16], partner_rest_offset_i}
                  : pv_x;
  assign num_d    = raw_x - $signed({2'b00, trigger_min_q});
  assign top      = (trigger_max_q != '0) ? {1'b0, trigger_max_q}
                                          : adtr_pkg::ONE_Q[16:0];
  assign span_raw = $signed({1'b0, top}) - $signed({2'b00, trigger_min_q});
  // Floor the span so a collapsed learned range cannot blow up the gain.
  assign span_d   = (span_raw < $signed({2'b00, adtr_pkg::MIN_SPAN}))
                  ? adtr_pkg::MIN_SPAN : span_raw[SW-1:0];
  assign range_on = (trigger_min_q != '0) || (trigger_max_q != '0);

  always_comb begin
    if (raw_x < 0) begin
      trig_clamp = '0;
    end else if (raw_x > adtr_pkg::ONE_Q) begin
      trig_clamp = adtr_pkg::ONE_Q;
    end else begin
      trig_clamp = raw_x;
    end
  end

  always_comb begin
    if (!comp_allowed_i) begin
      kind_a_d  = adtr_pkg::KIND_FIXED;
      fixed_a_d = raw_x;
    end else if (is_trigger_i) begin
      kind_a_d  = range_on ? adtr_pkg::KIND_DIV : adtr_pkg::KIND_FIXED;
      fixed_a_d = trig_clamp;
    end else if (is_stick_q) begin
      kind_a_d  = adtr_pkg::KIND_STICK;
      fixed_a_d = v_d;
    end else begin
      kind_a_d  = adtr_pkg::KIND_FIXED;
      fixed_a_d = v_d;
    end
  end

  logic                 valid_a_q;
  adtr_pkg::kind_e      kind_a_q;
  logic signed [VW-1:0] fixed_a_q;
  logic signed [VW-1:0] v_a_q;
  logic signed [VW-1:0] p_a_q;
  logic signed [VW-1:0] num_a_q;
  logic [SW-1:0]        span_a_q;
  logic                 has_partner_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else begin
      valid_a_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_a_q        <= kind_a_d;
    fixed_a_q       <= fixed_a_d;
    v_a_q           <= v_d;
    p_a_q           <= p_d;
    num_a_q         <= num_d;
    span_a_q        <= span_d;
    has_partner_a_q <= has_partner_i;
  end

  // ---------------------------------------------------------------------
  // Stage B: squares for the radial test, trigger end points, stick clamp
  // ---------------------------------------------------------------------
  logic signed [2*VW-1:0] vsq_full;
  logic signed [2*VW-1:0] psq_full;
  logic [31:0]            rsq_d;
  logic signed [VW-1:0]   v_abs;
  logic                   small_d;
  logic signed [VW-1:0]   clampv_d;
  adtr_pkg::kind_e        kind_b_d;
  logic signed [VW-1:0]   fixed_b_d;

  assign vsq_full = (2*VW)'(v_a_q) * (2*VW)'(v_a_q);
  assign psq_full = (2*VW)'(p_a_q) * (2*VW)'(p_a_q);
  assign rsq_d    = 32'(deadzone_radius_q) * 32'(deadzone_radius_q);
  assign v_abs    = (v_a_q < 0) ? -v_a_q : v_a_q;
  assign small_d  = (v_abs < $signed({2'b00, deadzone_radius_q}));

  always_comb begin
    if (v_a_q > adtr_pkg::ONE_Q) begin
      clampv_d = adtr_pkg::ONE_Q;
    end else if (v_a_q < -adtr_pkg::ONE_Q) begin
      clampv_d = -adtr_pkg::ONE_Q;
    end else begin
      clampv_d = v_a_q;
    end
  end

  // Settle the trigger end points here; only the open interval divides.
  always_comb begin
    kind_b_d  = kind_a_q;
    fixed_b_d = fixed_a_q;
    if (kind_a_q == adtr_pkg::KIND_DIV) begin
      if (num_a_q <= 0) begin
        kind_b_d  = adtr_pkg::KIND_FIXED;
        fixed_b_d = '0;
      end else if (num_a_q >= $signed({2'b00, span_a_q})) begin
        kind_b_d  = adtr_pkg::KIND_FIXED;
        fixed_b_d = adtr_pkg::ONE_Q;
      end
    end
  end

  logic                 valid_b_q;
  adtr_pkg::kind_e      kind_b_q;
  logic signed [VW-1:0] fixed_b_q;
  logic [SW-1:0]        num_b_q;
  logic [SW-1:0]        span_b_q;
  logic [34:0]          vsq_b_q;
  logic [34:0]          psq_b_q;
  logic [31:0]          rsq_b_q;
  logic                 small_b_q;
  logic                 has_partner_b_q;
  logic signed [VW-1:0] clampv_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_b_q        <= kind_b_d;
    fixed_b_q       <= fixed_b_d;
    num_b_q         <= num_a_q[SW-1:0];
    span_b_q        <= span_a_q;
    vsq_b_q         <= vsq_full[34:0];
    psq_b_q         <= psq_full[34:0];
    rsq_b_q         <= rsq_d;
    small_b_q       <= small_d;
    has_partner_b_q <= has_partner_a_q;
    clampv_b_q      <= clampv_d;
  end

  // ---------------------------------------------------------------------
  // Stage C: radial deadzone decision, hand the request to the divider
  // ---------------------------------------------------------------------
  logic [35:0]          dist_sq;
  logic                 inside_dz;
  logic                 zero_out;
  adtr_pkg::div_item_t  div_in;

  assign dist_sq   = {1'b0, vsq_b_q} + {1'b0, psq_b_q};
  assign inside_dz = has_partner_b_q ? (dist_sq < {4'b0, rsq_b_q}) : small_b_q;
  assign zero_out  = (deadzone_radius_q != '0) && inside_dz;

  always_comb begin
    div_in.is_div = (kind_b_q == adtr_pkg::KIND_DIV);
    div_in.rem    = num_b_q;
    div_in.span   = span_b_q;
    div_in.quo    = '0;
    if (kind_b_q == adtr_pkg::KIND_STICK) begin
      div_in.value = zero_out ? '0 : clampv_b_q;
    end else begin
      div_in.value = fixed_b_q;
    end
  end

  logic                 valid_c_q;
  adtr_pkg::div_item_t  div_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else begin
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    div_c_q <= div_in;
  end

  // ---------------------------------------------------------------------
  // Divider stages and output register
  // ---------------------------------------------------------------------
  adtr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_c_q),
    .in_item_i   (div_c_q),
    .out_valid_o (done_o),
    .out_value_o (corrected_value_o)
  );

endmodule

// ===== verif/axis_deadzone_trigger_remap_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for axis_deadzone_trigger_remap_unit: a directed table, then random
// requests under several register settings, each result checked against a local predictor.
// Depends on adtr_pkg and the unit under test.

module axis_deadzone_trigger_remap_unit_tb;
  import adtr_pkg::*;

  // Q15 scale and output saturation used by the predictor.
  localparam longint UNIT_Q      = longint'(1) << FRAC_BITS;
  localparam longint SPAN_FLOOR  = (UNIT_Q + 999) / 1000;
  localparam longint CORR_MAX    = 131071;
  localparam longint CORR_MIN    = -131072;
  localparam longint RAW_MAX     = 65535;
  localparam longint RAW_MIN     = -65536;

  // Word indexes past the register list; writes there must leave everything unchanged.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Settle time after the last result before touching registers or ending.
  localparam int SETTLE_CYCLES   = 24;
  localparam int N_BLOCKS        = 10;
  localparam int ITEMS_PER_BLOCK = 155;
  localparam int N_RANDOM        = N_BLOCKS * ITEMS_PER_BLOCK;
  localparam int CYCLE_LIMIT     = 300000;

  typedef struct packed {
    logic signed [16:0] raw;
    logic signed [16:0] pval;
    logic               has_p;
    logic               p_valid;
    logic signed [16:0] p_off;
    logic               trig;
    logic               allowed;
  } axis_req_t;

  typedef struct packed {
    logic               is_stick;
    logic [15:0]        tmin;
    logic [15:0]        tmax;
    logic signed [16:0] rest;
    logic [15:0]        dz;
  } axis_cfg_t;

  typedef struct packed {
    logic [2:0]         sel;
    axis_req_t          req;
    logic               typed;
    logic signed [17:0] want;
  } dir_row_t;

  // Register settings for the directed rows. Setting 0 is the reset state.
  localparam int N_DIR_CFG = 6;
  localparam axis_cfg_t DIR_CFG [N_DIR_CFG] = '{
    '{0, 0,     0,     0,      0},      // reset values
    '{0, 1000,  20000, 0,      0},      // learned trigger range
    '{0, 20000, 20010, 0,      0},      // span below the floor
    '{1, 0,     0,     100,    5000},   // stick with deadzone
    '{1, 32768, 32768, -32768, 32768},  // upper extremes, lowest rest offset
    '{0, 0,     0,     32768,  0}       // highest rest offset, not a stick
  };

  // sel, {raw, partner, has_partner, partner_ofs_valid, partner_ofs, trigger, allowed},
  // typed, want. Untyped rows go through the predictor.
  localparam int N_DIR = 24;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // pass through, trigger flag or not
    '{0, '{-65536, 0, 0, 0, 0, 0, 0}, 1, -65536},
    '{0, '{65535,  0, 0, 0, 0, 1, 0}, 1, 65535},
    // unlearned trigger: plain clamp to 0..1
    '{0, '{-100,   0, 0, 0, 0, 1, 1}, 1, 0},
    '{0, '{40000,  0, 0, 0, 0, 1, 1}, 1, 32768},
    // plain axis, zero offset, no stick
    '{0, '{-65536, 0, 0, 0, 0, 0, 1}, 1, -65536},
    // learned range: below floor, at floor, at top, inside
    '{1, '{500,    0, 0, 0, 0, 1, 1}, 1, 0},
    '{1, '{1000,   0, 0, 0, 0, 1, 1}, 1, 0},
    '{1, '{20000,  0, 0, 0, 0, 1, 1}, 1, 32768},
    '{1, '{10000,  0, 0, 0, 0, 1, 1}, 0, 0},
    // span floored to the minimum
    '{2, '{20010,  0, 0, 0, 0, 1, 1}, 0, 0},
    '{2, '{20033,  0, 0, 0, 0, 1, 1}, 1, 32768},
    // radial deadzone with a partner, inside and outside the circle
    '{3, '{3100,   3000,  1, 0, 0,      0, 1}, 1, 0},
    '{3, '{3100,   3500,  1, 1, -1000,  0, 1}, 0, 0},
    // no partner: partner offset flag ignored, magnitude test only
    '{3, '{5099,   65535, 0, 1, 32768,  0, 1}, 1, 0},
    '{3, '{5100,   0,     0, 0, 0,      0, 1}, 1, 5000},
    '{3, '{-4900,  0,     0, 0, 0,      0, 1}, 1, -5000},
    // stick clamp to -1..1
    '{3, '{65535,  0,     0, 0, 0,      0, 1}, 1, 32768},
    '{3, '{-65536, 0,     0, 0, 0,      0, 1}, 1, -32768},
    // trigger flag wins over the stick register
    '{3, '{65535,  0,     0, 0, 0,      1, 1}, 1, 32768},
    // extremes
    '{4, '{65535,  65535, 1, 1, -32768, 0, 1}, 1, 32768},
    '{4, '{-65536, -65536, 1, 1, 32768, 0, 1}, 0, 0},
    '{4, '{65535,  0,     0, 0, 0,      1, 1}, 1, 32768},
    '{4, '{32800,  0,     0, 0, 0,      1, 1}, 0, 0},
    '{5, '{-65536, 0,     0, 0, 0,      0, 1}, 1, -98304}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      start;
  logic                      busy;
  logic signed [16:0]        raw_value_i;
  logic signed [16:0]        partner_value_i;
  logic                      has_partner_i;
  logic                      partner_offset_valid_i;
  logic signed [16:0]        partner_rest_offset_i;
  logic                      is_trigger_i;
  logic                      comp_allowed_i;
  logic                      done_o;
  logic signed [17:0]        corrected_value_o;

  axis_cfg_t                 shadow_cfg;
  logic signed [17:0]        corrected_due [$];
  int                        mismatch_count;
  int                        sender_idle_pct;
  int                        cycle_count;

  axis_deadzone_trigger_remap_unit u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .start                  (start),
    .busy                   (busy),
    .raw_value_i            (raw_value_i),
    .partner_value_i        (partner_value_i),
    .has_partner_i          (has_partner_i),
    .partner_offset_valid_i (partner_offset_valid_i),
    .partner_rest_offset_i  (partner_rest_offset_i),
    .is_trigger_i           (is_trigger_i),
    .comp_allowed_i         (comp_allowed_i),
    .done_o                 (done_o),
    .corrected_value_o      (corrected_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop: a hung unit or a lost result ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint clamp_q(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Predict the corrected sample for one request under the given settings.
  function automatic logic signed [17:0] remap_axis(axis_req_t r, axis_cfg_t c);
    longint raw, v, p, lo, top, span, num, rad, res;
    raw = r.raw;
    if (!r.allowed) begin
      res = raw;
    end else if (r.trig) begin
      if (c.tmin == 0 && c.tmax == 0) begin
        res = clamp_q(raw, 0, UNIT_Q);
      end else begin
        lo   = c.tmin;
        top  = (c.tmax != 0) ? longint'(c.tmax) : UNIT_Q;
        span = top - lo;
        if (span < SPAN_FLOOR) span = SPAN_FLOOR;
        num  = raw - lo;
        if (num <= 0) res = 0;
        else if (num >= span) res = UNIT_Q;
        else res = (num * UNIT_Q) / span;
      end
    end else begin
      v = raw - longint'(c.rest);
      if (c.is_stick) begin
        if (c.dz != 0) begin
          rad = c.dz;
          if (r.has_p) begin
            // partner offset only counts when flagged valid
            p = r.p_valid ? longint'(r.pval) - longint'(r.p_off) : longint'(r.pval);
            if (v * v + p * p < rad * rad) v = 0;
          end else if ((v < 0 ? -v : v) < rad) begin
            v = 0;
          end
        end
        v = clamp_q(v, -UNIT_Q, UNIT_Q);
      end
      res = v;
    end
    res = clamp_q(res, CORR_MIN, CORR_MAX);
    return res[17:0];
  endfunction

  // Mirror one accepted register write into the shadow settings.
  function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_IS_STICK:  shadow_cfg.is_stick = data[0];
      REG_TRIG_MIN:  shadow_cfg.tmin     = data[15:0];
      REG_TRIG_MAX:  shadow_cfg.tmax     = data[15:0];
      REG_REST_OFS:  shadow_cfg.rest     = data[16:0];
      REG_DZ_RADIUS: shadow_cfg.dz       = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] pick_q15();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'($urandom_range(32768));
      2:       return 16'($urandom_range(3000));
      default: return 16'd32768;
    endcase
  endfunction

  function automatic axis_cfg_t rand_cfg();
    axis_cfg_t c;
    longint    top;
    c.is_stick = 1'($urandom_range(1));
    c.tmin     = pick_q15();
    // a narrow span near the floor is worth a quarter of the draws
    if ($urandom_range(3) == 0) begin
      top    = clamp_q(longint'(c.tmin) + $urandom_range(60), 0, UNIT_Q);
      c.tmax = 16'(top);
    end else begin
      c.tmax = pick_q15();
    end
    case ($urandom_range(3))
      0:       c.rest = 17'sd0;
      1:       c.rest = 17'(longint'($urandom_range(65536)) - 32768);
      2:       c.rest = 17'(longint'($urandom_range(1000)) - 500);
      default: c.rest = $urandom_range(1) ? 17'sd32768 : -17'sd32768;
    endcase
    c.dz = pick_q15();
    return c;
  endfunction

  // Build a random request, steered towards the range edges and the deadzone circle.
  function automatic axis_req_t rand_req(axis_cfg_t c);
    axis_req_t r;
    longint    raw, p, top, span, reach, centre;
    r.allowed = ($urandom_range(9) != 0);
    r.trig    = ($urandom_range(2) == 0);
    r.has_p   = 1'($urandom_range(1));
    r.p_valid = 1'($urandom_range(1));
    r.p_off   = 17'(longint'($urandom_range(65536)) - 32768);
    reach     = longint'(c.dz) + 64;
    case ($urandom_range(4))
      0: raw = longint'($urandom_range(131071)) + RAW_MIN;
      1: begin
        case ($urandom_range(4))
          0:       raw = RAW_MIN;
          1:       raw = RAW_MAX;
          2:       raw = 0;
          3:       raw = -UNIT_Q;
          default: raw = UNIT_Q;
        endcase
      end
      2: begin
        top  = (c.tmax != 0) ? longint'(c.tmax) : UNIT_Q;
        span = top - longint'(c.tmin);
        if (span < SPAN_FLOOR) span = SPAN_FLOOR;
        raw  = longint'(c.tmin) - 40 + $urandom_range(32'(span + 80));
      end
      default: raw = longint'(c.rest) + $urandom_range(32'(2 * reach)) - reach;
    endcase
    r.raw = 17'(clamp_q(raw, RAW_MIN, RAW_MAX));
    if ($urandom_range(2) == 0) begin
      p = longint'($urandom_range(131071)) + RAW_MIN;
    end else begin
      centre = r.p_valid ? longint'(r.p_off) : 0;
      p      = centre + $urandom_range(32'(2 * reach)) - reach;
    end
    r.pval = 17'(clamp_q(p, RAW_MIN, RAW_MAX));
    return r;
  endfunction

  // Offer one request, idling first at the current rate; queue its result once taken.
  task automatic send_req(axis_req_t r, logic typed, logic signed [17:0] want);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start                  <= 1'b1;
    raw_value_i            <= r.raw;
    partner_value_i        <= r.pval;
    has_partner_i          <= r.has_p;
    partner_offset_valid_i <= r.p_valid;
    partner_rest_offset_i  <= r.p_off;
    is_trigger_i           <= r.trig;
    comp_allowed_i         <= r.allowed;
    do @(posedge clk_i); while (busy !== 1'b0);
    corrected_due.push_back(typed ? want : remap_axis(r, shadow_cfg));
  endtask

  // Hold off new requests until every queued result is back, then let the pipe settle.
  task automatic drain_requests();
    start <= 1'b0;
    while (corrected_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB write: setup cycle, then access until pready. Leaves psel high.
  task automatic apb_write(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    apply_reg(idx, data);
  endtask

  task automatic write_config(axis_cfg_t c, logic spare);
    apb_write(REG_IS_STICK,  32'(c.is_stick));
    apb_write(REG_TRIG_MIN,  32'(c.tmin));
    apb_write(REG_TRIG_MAX,  32'(c.tmax));
    apb_write(REG_REST_OFS,  {{15{c.rest[16]}}, c.rest});
    apb_write(REG_DZ_RADIUS, 32'(c.dz));
    // poke an unmapped word; nothing may change
    if (spare) apb_write(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result checker: every strobe must match the oldest queued expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      if (corrected_due.size() == 0) begin
        $error("corrected_value: expected none, got %0d", corrected_value_o);
        mismatch_count++;
      end else begin
        if (done_o !== 1'b1 || corrected_value_o !== corrected_due[0]) begin
          $error("corrected_value: expected %0d, got %0d", corrected_due[0],
                 corrected_value_o);
          mismatch_count++;
        end
        void'(corrected_due.pop_front());
      end
    end
  end

  initial begin
    int        cur_sel;
    int        item_no;
    axis_cfg_t next_cfg;

    mismatch_count         = 0;
    sender_idle_pct        = 0;
    shadow_cfg             = DIR_CFG[0];
    rst_ni                 <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    start                  <= 1'b0;
    raw_value_i            <= '0;
    partner_value_i        <= '0;
    has_partner_i          <= 1'b0;
    partner_offset_valid_i <= 1'b0;
    partner_rest_offset_i  <= '0;
    is_trigger_i           <= 1'b0;
    comp_allowed_i         <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: start on reset values, reprogram only when the row's setting changes.
    cur_sel = 0;
    for (int i = 0; i < N_DIR; i++) begin
      if (int'(DIR_ROWS[i].sel) != cur_sel) begin
        drain_requests();
        cur_sel = DIR_ROWS[i].sel;
        write_config(DIR_CFG[cur_sel], 1'b1);
      end
      send_req(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    // Random blocks: first at the register extremes, second at reset values, the rest drawn at random.
    // Idle rate: light in the first third, heavy in the second, none in the last.
    item_no = 0;
    for (int blk = 0; blk < N_BLOCKS; blk++) begin
      drain_requests();
      if (blk == 0) next_cfg = DIR_CFG[4];
      else if (blk == 1) next_cfg = DIR_CFG[0];
      else next_cfg = rand_cfg();
      write_config(next_cfg, 1'($urandom_range(1)));
      for (int k = 0; k < ITEMS_PER_BLOCK; k++) begin
        if (item_no < N_RANDOM / 3) sender_idle_pct = 19;
        else if (item_no < 2 * N_RANDOM / 3) sender_idle_pct = 88;
        else sender_idle_pct = 0;
        // now and then drain the pipe mid-block
        if ($urandom_range(249) == 0) drain_requests();
        send_req(rand_req(shadow_cfg), 1'b0, '0);
        item_no++;
      end
    end

    drain_requests();
    if (mismatch_count == 0 && corrected_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
